/* src/aoa_pkg.sv */
// ----------------------------------------------------------------------------
// aoa_pkg
// Shared types and constants of the adaptive orientation averager.
// ----------------------------------------------------------------------------
`default_nettype none

package aoa_pkg;

  localparam int DATA_W         = 16;
  localparam int RING_DEPTH_DEF = 16;
  localparam int WIN_CFG_W      = 5;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET    = WIN_CFG_W'(8);
  localparam logic [DATA_W-1:0]    THRESHOLD_RESET = DATA_W'(546);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LENGTH   = 2'd0,
    REG_QUIET_THRESHOLD = 2'd1,
    REG_FILTER_ENABLE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] roll;
    logic signed [DATA_W-1:0] pitch;
    logic signed [DATA_W-1:0] yaw;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

endpackage

`default_nettype wire

/* src/aoa_ram.sv */
// ----------------------------------------------------------------------------
// aoa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/aoa_div.sv */
// ----------------------------------------------------------------------------
// aoa_div
// Three-lane restoring divider, one quotient bit per cycle, truncating
// signed sums toward zero by a common unsigned window size.
// ----------------------------------------------------------------------------
`default_nettype none

module aoa_div #(
  parameter int SUM_W = 21,
  parameter int W_W   = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [SUM_W-1:0]          dividend [3],
  input  wire logic        [W_W-1:0]            divisor,
  output logic                                  done,
  output logic signed [aoa_pkg::DATA_W-1:0]     quotient [3]
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  step_cnt;
  logic [W_W-1:0]    dvs;
  logic [SUM_W-1:0]  quo [3];
  logic [W_W-1:0]    rem [3];
  logic              neg [3];

  logic [W_W:0]      rem_shift [3];
  logic              fits [3];
  logic [SUM_W-1:0]  signed_quo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_shift[i]  = {rem[i], quo[i][SUM_W-1]};
      fits[i]       = rem_shift[i] >= {1'b0, dvs};
      signed_quo[i] = neg[i] ? (~quo[i] + 1'b1) : quo[i];
      quotient[i]   = signed_quo[i][aoa_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= CNT_W'(SUM_W);
        dvs      <= divisor;
        for (int i = 0; i < 3; i++) begin
          neg[i] <= dividend[i][SUM_W-1];
          quo[i] <= dividend[i][SUM_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
          rem[i] <= '0;
        end
      end else if (busy) begin
        step_cnt <= step_cnt - 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (fits[i]) begin
            rem[i] <= W_W'(rem_shift[i] - {1'b0, dvs});
            quo[i] <= {quo[i][SUM_W-2:0], 1'b1};
          end else begin
            rem[i] <= rem_shift[i][W_W-1:0];
            quo[i] <= {quo[i][SUM_W-2:0], 1'b0};
          end
        end
        if (step_cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/adaptive_orientation_average_unit.sv */
// Path, input beat to output beat valid: a pass-through sample goes from IDLE
// to OUT; a suspended sample passes CHECK on the way; an averaged sample passes
// CHECK, SUM (one ring read per cycle) and DIV (the bit-serial divider, SUM_W = 21
// at RING_DEPTH 16) before OUT.
// Throughput: one sample at a time; the next can be taken in the cycle after the result
// enters the output register. Reset: synchronous, clears the ring at once via valid bits.
// ----------------------------------------------------------------------------
// adaptive_orientation_average_unit
// Yaw/pitch/roll moving average over a RAM ring with motion-triggered and configurable bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_orientation_average_unit #(
  parameter int RING_DEPTH = aoa_pkg::RING_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [aoa_pkg::SAMPLE_W-1:0]      s_tdata,   // yaw_raw, pitch_raw, roll_raw
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [aoa_pkg::SAMPLE_W-1:0]           m_tdata,   // yaw_out, pitch_out, roll_out
  output logic                                   m_tuser,   // averaging_active
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [aoa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [aoa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int W_W    = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = W_W + 1;
  localparam int SUM_W  = aoa_pkg::DATA_W + W_W;
  localparam int DW     = aoa_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;

  logic [aoa_pkg::WIN_CFG_W-1:0] window_length;
  logic [DW-1:0]                 quiet_threshold;
  logic                          filter_enable;

  logic [SLOT_W-1:0]     write_slot;
  logic [CNT_W-1:0]      suspend_count;
  logic [RING_DEPTH-1:0] valid;
  aoa_pkg::sample_t      fill_value;
  aoa_pkg::sample_t      sample;
  aoa_pkg::sample_t      res;
  logic                  res_active;
  logic [W_W-1:0]        win;
  logic [SLOT_W-1:0]     sum_idx;
  logic [W_W-1:0]        iss_cnt;
  logic                  pend;
  logic                  rd_valid;
  logic                  div_start;
  logic signed [SUM_W-1:0] acc [3];

  logic [W_W-1:0]        w_eff;
  logic [SLOT_W-1:0]     cur_slot;
  logic [SLOT_W-1:0]     sum_idx_next;
  logic [SLOT_W-1:0]     raddr;
  logic [aoa_pkg::SAMPLE_W-1:0] rdata;
  aoa_pkg::sample_t      rd_word;
  logic signed [DW:0]    dy;
  logic signed [DW:0]    dp;
  logic [DW:0]           ady;
  logic [DW:0]           adp;
  logic                  jump;
  logic [CNT_W-1:0]      cnt_load;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  div_done;
  logic signed [DW-1:0]  quot [3];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    if (window_length == '0) begin
      w_eff = W_W'(1);
    end else if (32'(window_length) > RING_DEPTH) begin
      w_eff = W_W'(RING_DEPTH);
    end else begin
      w_eff = W_W'(window_length);
    end
  end

  assign cur_slot     = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign sum_idx_next = (sum_idx == '0) ? SLOT_W'(RING_DEPTH - 1) : sum_idx - 1'b1;
  assign raddr        = (state == ST_IDLE) ? write_slot : sum_idx;
  assign rd_word      = rd_valid ? aoa_pkg::sample_t'(rdata) : fill_value;

  assign dy  = {sample.yaw[DW-1], sample.yaw} - {rd_word.yaw[DW-1], rd_word.yaw};
  assign dp  = {sample.pitch[DW-1], sample.pitch} - {rd_word.pitch[DW-1], rd_word.pitch};
  assign ady = dy[DW] ? (~dy + 1'b1) : dy;
  assign adp = dp[DW] ? (~dp + 1'b1) : dp;
  assign jump = (ady > {1'b0, quiet_threshold}) || (adp > {1'b0, quiet_threshold});
  assign cnt_load = jump ? {win, 1'b0} : suspend_count;
  assign cnt_dec  = cnt_load - 1'b1;

  aoa_ram #(
    .WIDTH (aoa_pkg::SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_CHECK),
    .waddr (cur_slot),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  aoa_div #(
    .SUM_W (SUM_W),
    .W_W   (W_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (win),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= aoa_pkg::WINDOW_RESET;
      quiet_threshold <= aoa_pkg::THRESHOLD_RESET;
      filter_enable   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        aoa_pkg::REG_WINDOW_LENGTH:   window_length   <= cfg_data[aoa_pkg::WIN_CFG_W-1:0];
        aoa_pkg::REG_QUIET_THRESHOLD: quiet_threshold <= cfg_data[DW-1:0];
        aoa_pkg::REG_FILTER_ENABLE:   filter_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_slot    <= '0;
      suspend_count <= CNT_W'(1);
      valid         <= '0;
      fill_value    <= '0;
      m_tvalid      <= 1'b0;
      pend          <= 1'b0;
      div_start     <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_valid  <= valid[raddr];
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata;
            win    <= w_eff;
            if (filter_enable) begin
              state <= ST_CHECK;
            end else begin
              res        <= s_tdata;
              res_active <= 1'b0;
              state      <= ST_OUT;
            end
          end
        end
        ST_CHECK: begin
          write_slot <= cur_slot;
          if (cnt_load != '0 && cnt_dec == '0) begin
            valid      <= '0;
            fill_value <= sample;
          end else begin
            valid[cur_slot] <= 1'b1;
          end
          if (cnt_load != '0) begin
            suspend_count <= cnt_dec;
            res           <= sample;
            res_active    <= 1'b0;
            state         <= ST_OUT;
          end else begin
            suspend_count <= cnt_load;
            sum_idx       <= cur_slot;
            iss_cnt       <= '0;
            for (int i = 0; i < 3; i++) begin
              acc[i] <= '0;
            end
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (pend) begin
            acc[0] <= acc[0] + {{W_W{rd_word.yaw[DW-1]}}, rd_word.yaw};
            acc[1] <= acc[1] + {{W_W{rd_word.pitch[DW-1]}}, rd_word.pitch};
            acc[2] <= acc[2] + {{W_W{rd_word.roll[DW-1]}}, rd_word.roll};
          end
          if (iss_cnt != win) begin
            pend    <= 1'b1;
            iss_cnt <= iss_cnt + 1'b1;
            sum_idx <= sum_idx_next;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res.yaw    <= quot[0];
            res.pitch  <= quot[1];
            res.roll   <= quot[2];
            res_active <= 1'b1;
            state      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tuser  <= res_active;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/aoa_checker.sv */
// ----------------------------------------------------------------------------
// aoa_checker
// Port-level checks of the orientation averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aoa_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [aoa_pkg::SAMPLE_W-1:0] m_tdata,
  input wire logic                         m_tuser
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a sample is in work");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind adaptive_orientation_average_unit aoa_checker u_aoa_checker (.*);

`default_nettype wire

/* sim/tb_adaptive_orientation_average_unit.sv */
// ----------------------------------------------------------------------------
// tb_adaptive_orientation_average_unit
// Streams yaw/pitch/roll samples through the averager under changing window,
// threshold and bypass settings, with random source gaps and sink stalls. A
// cycle-free predictor of the ring, the motion detector and the suspension
// count computes each expected output beat, and a scoreboard compares every
// output beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adaptive_orientation_average_unit;
  import aoa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 110;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic    active;
    sample_t angles;
  } orient_result_t;

  typedef struct {
    sample_t angles;
    bit      wait_for_drain;
  } queued_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata   = '0;  // yaw_raw, pitch_raw, roll_raw
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]    m_tdata;         // yaw_out, pitch_out, roll_out
  logic                   m_tuser;         // averaging_active
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  adaptive_orientation_average_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  logic [WIN_CFG_W-1:0] cfg_window    = WINDOW_RESET;
  logic [DATA_W-1:0]    cfg_threshold = THRESHOLD_RESET;
  logic                 cfg_filter    = 1'b1;
  sample_t              angle_ring [RING_DEPTH_DEF];
  int                   newest_slot   = 0;
  int                   suspend_left  = 1;

  queued_sample_t sample_backlog [$];
  orient_result_t predicted_outputs [$];
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             mismatch_count = 0;
  int             cycle_count    = 0;

  function automatic int abs_gap(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic orient_result_t orientation_filter_step(sample_t s);
    orient_result_t r;
    int w, prev, cur, idx, sum_y, sum_p, sum_r;
    r.angles = s;
    r.active = 1'b0;
    if (!cfg_filter) return r;
    w = int'(cfg_window);
    if (w < 1) w = 1;
    if (w > RING_DEPTH_DEF) w = RING_DEPTH_DEF;
    prev = newest_slot;
    cur  = (prev + 1) % RING_DEPTH_DEF;
    newest_slot = cur;
    angle_ring[cur] = s;
    if (abs_gap(angle_ring[prev].yaw, s.yaw) > int'(cfg_threshold) ||
        abs_gap(angle_ring[prev].pitch, s.pitch) > int'(cfg_threshold))
      suspend_left = 2 * w;
    if (suspend_left != 0) begin
      suspend_left--;
      if (suspend_left == 0) begin
        foreach (angle_ring[i]) angle_ring[i] = s;
      end
      return r;
    end
    sum_y = 0;
    sum_p = 0;
    sum_r = 0;
    idx = cur;
    for (int k = 0; k < w; k++) begin
      sum_y += int'(angle_ring[idx].yaw);
      sum_p += int'(angle_ring[idx].pitch);
      sum_r += int'(angle_ring[idx].roll);
      idx = (idx + RING_DEPTH_DEF - 1) % RING_DEPTH_DEF;
    end
    r.angles.yaw   = 16'(sum_y / w);
    r.angles.pitch = 16'(sum_p / w);
    r.angles.roll  = 16'(sum_r / w);
    r.active = 1'b1;
    return r;
  endfunction

  function automatic sample_t angles(int y, int p, int r);
    sample_t s;
    s.yaw   = 16'(y);
    s.pitch = 16'(p);
    s.roll  = 16'(r);
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int signed_step(int span);
    int d;
    d = $urandom_range(0, span);
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  // mostly quiet walks, with boundary steps, jumps, extremes and noise
  function automatic sample_t make_sample(sample_t last, int th);
    sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    s.roll = 16'($urandom);
    if (pick < 2) begin
      s.yaw   = 16'($urandom);
      s.pitch = 16'($urandom);
    end else if (pick < 4) begin
      s.yaw   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      s.pitch = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      s.roll  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else if (pick < 6) begin
      s.yaw   = sat16(int'(last.yaw) + ($urandom_range(0, 1) ? th + 1 : -(th + 1)));
      s.pitch = last.pitch;
      if ($urandom_range(0, 1)) begin
        s.pitch = sat16(int'(last.pitch) + ($urandom_range(0, 1) ? th + 1 : -(th + 1)));
        s.yaw   = last.yaw;
      end
    end else if (pick < 14) begin
      s.yaw   = sat16(int'(last.yaw) + ($urandom_range(0, 1) ? th : -th));
      s.pitch = sat16(int'(last.pitch) + ($urandom_range(0, 1) ? th : -th));
    end else begin
      s.yaw   = sat16(int'(last.yaw) + signed_step(th));
      s.pitch = sat16(int'(last.pitch) + signed_step(th));
    end
    return s;
  endfunction

  function automatic void queue_sample(sample_t s, bit drain);
    queued_sample_t q;
    q.angles = s;
    q.wait_for_drain = drain;
    sample_backlog.push_back(q);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH:   cfg_window    = val[WIN_CFG_W-1:0];
      REG_QUIET_THRESHOLD: cfg_threshold = val;
      REG_FILTER_ENABLE:   cfg_filter    = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    while (sample_backlog.size() != 0 || s_tvalid || predicted_outputs.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_samples
    queued_sample_t head;
    bit take;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predicted_outputs.push_back(orientation_filter_step(sample_t'(s_tdata)));
      if (!s_tvalid || s_tready) begin
        take = 1'b0;
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          if (!(sample_backlog[0].wait_for_drain && predicted_outputs.size() != 0))
            take = 1'b1;
        end
        if (take) begin
          head = sample_backlog.pop_front();
          s_tdata  <= head.angles;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    orient_result_t want;
    sample_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (predicted_outputs.size() == 0) begin
          report_mismatch("output beat with no prediction pending");
        end else begin
          want = predicted_outputs.pop_front();
          check_field("yaw_out", int'(got.yaw), int'(want.angles.yaw));
          check_field("pitch_out", int'(got.pitch), int'(want.angles.pitch));
          check_field("roll_out", int'(got.roll), int'(want.angles.roll));
          check_field("averaging_active", int'(m_tuser), int'(want.active));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sample_t walk_last;
    logic [CFG_DATA_W-1:0] win_data, th_data, en_data;
    foreach (angle_ring[i]) angle_ring[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first beat after reset, threshold edges, a full suspension, then bypass
    queue_sample(angles(5, -3, 32767), 1'b0);
    queue_sample(angles(551, -3, -32768), 1'b0);
    queue_sample(angles(551, -549, -1), 1'b1);
    queue_sample(angles(551, -549, 1), 1'b0);
    queue_sample(angles(551, -549, 0), 1'b0);
    queue_sample(angles(551, -1096, -32768), 1'b0);
    for (int k = 0; k < 15; k++)
      queue_sample(angles(551 + k, -1096 - k, k * 2000 - 15000), 1'b0);
    queue_sample(angles(560, -1100, 32767), 1'b0);
    wait_until_drained();
    write_register(REG_FILTER_ENABLE, 16'd0);
    queue_sample(angles(32767, -32768, -1), 1'b0);
    queue_sample(angles(-32768, 32767, 0), 1'b0);
    queue_sample(angles(0, 0, 12345), 1'b0);
    wait_until_drained();

    walk_last = angles(560, -1100, 0);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin win_data = 16'd16;   th_data = 16'hFFFF; en_data = 16'd1;     end
        1: begin win_data = 16'hFFE0; th_data = 16'd300;  en_data = 16'd1;     end
        2: begin win_data = 16'h001F; th_data = 16'd1000; en_data = 16'd1;     end
        3: begin win_data = 16'd5;    th_data = 16'd0;    en_data = 16'd1;     end
        4: begin win_data = 16'd8;    th_data = 16'd546;  en_data = 16'hFFFE;  end
        5: begin win_data = 16'd2;    th_data = 16'd2000; en_data = 16'd1;     end
        6: begin win_data = 16'd16;   th_data = 16'd546;  en_data = 16'd1;     end
        default: begin win_data = 16'd1; th_data = 16'd100; en_data = 16'h0003; end
      endcase
      write_register(REG_WINDOW_LENGTH, win_data);
      write_register(REG_QUIET_THRESHOLD, th_data);
      write_register(REG_FILTER_ENABLE, en_data);
      if (ph == 1 || ph == 5)
        write_register(REG_UNUSED, 16'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        walk_last = make_sample(walk_last, int'(cfg_threshold));
        queue_sample(walk_last, n == PHASE_BEATS / 2 || $urandom_range(0, 99) == 0);
      end
      wait_until_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/aoa_pkg.sv
src/aoa_ram.sv
src/aoa_div.sv
src/adaptive_orientation_average_unit.sv
src/aoa_checker.sv
sim/tb_adaptive_orientation_average_unit.sv
